/* rtl/core/rpc_pkg.sv */
`timescale 1ns / 1ps
package rpc_pkg;
	localparam int FRAC_BITS = 24;
	localparam int NUM_W = ((FRAC_BITS + 33 > 65) ? FRAC_BITS + 33 : 65) + 3;
	localparam int DEN_W = ((2 * FRAC_BITS + 2 > 65) ? 2 * FRAC_BITS + 2 : 65) + 3;
	localparam int QUO_W = 36;
	localparam int REM_W = DEN_W + QUO_W;
	localparam int BITS_PER_STAGE = 2;
	localparam int DIV_STAGES = QUO_W / BITS_PER_STAGE;

	typedef enum logic {
		OP_COMPOSE  = 1'b0,
		OP_RELATIVE = 1'b1
	} op_t;

	typedef struct packed {
		logic               neg;
		logic               ovf;
		logic [DEN_W-1:0]   den;
		logic [REM_W-1:0]   rem;
		logic [QUO_W-1:0]   quo;
	} div_lane_t;

	typedef struct packed {
		logic             singular;
		logic [DEN_W-1:0] den;
	} ctl_t;
endpackage

/* rtl/core/rpc_div_lane.sv */
`timescale 1ns / 1ps
module rpc_div_lane (
	input  logic                  clk,
	input  logic                  en,
	input  rpc_pkg::div_lane_t    din,
	output rpc_pkg::div_lane_t    dout
);
	import rpc_pkg::*;

	div_lane_t nxt;
	logic [DEN_W:0] trial;
	logic [REM_W-1:0] r;

	always_comb begin
		nxt = din;
		r = din.rem;
		trial = '0;
		for (int b = 0; b < BITS_PER_STAGE; b++) begin
			r = {r[REM_W-2:0], 1'b0};
			trial = {1'b0, r[REM_W-1 -: DEN_W]} - {1'b0, din.den};
			nxt.quo = {nxt.quo[QUO_W-2:0], ~trial[DEN_W]};
			if (!trial[DEN_W]) begin
				r[REM_W-1 -: DEN_W] = trial[DEN_W-1:0];
			end
		end
		nxt.rem = r;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dout <= nxt;
		end
	end
endmodule

/* rtl/core/rodrigues_param_compose.sv */
`timescale 1ns / 1ps
// The pipeline takes one item per cycle while the output is not stalled;
// the eighteen two-bit divider stages per component set the depth.
// A stall holds the whole pipeline in place through a common enable.
// Reset clears only the valid bits; the data registers are not reset.
module rodrigues_param_compose (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [191:0] s_tdata,  // first_x/y/z, second_x/y/z
	input  logic         s_tuser,  // operation
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [95:0]  m_tdata,  // result_x/y/z
	output logic         m_tuser   // singular
);
	import rpc_pkg::*;

	localparam int NST = DIV_STAGES + 6;
	logic [NST-1:0] v_q;
	logic en;
	assign en = !m_tvalid || m_tready;
	assign s_tready = en;
	assign m_tvalid = v_q[NST-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[NST-2:0], s_tvalid};
		end
	end

	// Stage 1: register inputs.
	logic op_s1;
	logic signed [31:0] a_s1 [3];
	logic signed [31:0] b_s1 [3];
	always_ff @(posedge clk) begin
		if (en) begin
			op_s1 <= s_tuser;
			for (int k = 0; k < 3; k++) begin
				a_s1[k] <= s_tdata[32*k +: 32];
				b_s1[k] <= s_tdata[96+32*k +: 32];
			end
		end
	end

	// Stage 2: nine products.
	logic op_s2;
	logic signed [63:0] ab_s2 [3];
	logic signed [63:0] cp_s2 [3];
	logic signed [63:0] cn_s2 [3];
	logic signed [32:0] sum_s2 [3];
	always_ff @(posedge clk) begin
		if (en) begin
			op_s2 <= op_s1;
			for (int k = 0; k < 3; k++) begin
				ab_s2[k] <= a_s1[k] * b_s1[k];
				cp_s2[k] <= a_s1[(k+1)%3] * b_s1[(k+2)%3];
				cn_s2[k] <= a_s1[(k+2)%3] * b_s1[(k+1)%3];
				sum_s2[k] <= (op_s1 == OP_RELATIVE) ?
					33'(a_s1[k]) - 33'(b_s1[k]) : 33'(a_s1[k]) + 33'(b_s1[k]);
			end
		end
	end

	// Stage 3: numerators and denominator.
	logic signed [NUM_W-1:0] num_s3 [3];
	logic signed [DEN_W-1:0] den_s3;
	logic signed [DEN_W-1:0] dot;
	always_comb begin
		dot = DEN_W'(ab_s2[0]) + DEN_W'(ab_s2[1]) + DEN_W'(ab_s2[2]);
	end
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				num_s3[k] <= (NUM_W'(sum_s2[k]) <<< FRAC_BITS)
					+ NUM_W'(cp_s2[k]) - NUM_W'(cn_s2[k]);
			end
			den_s3 <= (op_s2 == OP_RELATIVE) ?
				(DEN_W'(1) <<< (2*FRAC_BITS)) + dot :
				(DEN_W'(1) <<< (2*FRAC_BITS)) - dot;
		end
	end

	// Stage 4: magnitudes and the scaled dividend.
	div_lane_t lane_s4 [3];
	ctl_t ctl_s4;
	logic [DEN_W-1:0] dmag;
	logic [NUM_W-1:0] nmag [3];
	always_comb begin
		dmag = den_s3[DEN_W-1] ? DEN_W'(-den_s3) : DEN_W'(den_s3);
		for (int k = 0; k < 3; k++) begin
			nmag[k] = num_s3[k][NUM_W-1] ? NUM_W'(-num_s3[k]) : NUM_W'(num_s3[k]);
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s4.singular <= (den_s3 == '0);
			ctl_s4.den <= dmag;
			for (int k = 0; k < 3; k++) begin
				lane_s4[k].neg <= num_s3[k][NUM_W-1] ^ den_s3[DEN_W-1];
				lane_s4[k].ovf <= 1'b0;
				lane_s4[k].den <= dmag;
				lane_s4[k].rem <= REM_W'({nmag[k], {FRAC_BITS{1'b0}}});
				lane_s4[k].quo <= '0;
			end
		end
	end

	// Stage 5: the quotient reaches 2^QUO_W exactly when the dividend bits
	// above the quotient bits are not below the divisor, and then it saturates.
	div_lane_t lane_in [3];
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			lane_in[k] = lane_s4[k];
			lane_in[k].ovf = (lane_s4[k].rem[REM_W-1 -: DEN_W] >= lane_s4[k].den);
		end
	end

	div_lane_t lane_out [3];
	for (genvar k = 0; k < 3; k++) begin : g_lane
		div_lane_t pre_s5;
		div_lane_t chain [DIV_STAGES+1];
		always_ff @(posedge clk) begin
			if (en) begin
				pre_s5 <= lane_in[k];
			end
		end
		assign chain[0] = pre_s5;
		for (genvar s = 0; s < DIV_STAGES; s++) begin : g_st
			rpc_div_lane u_st (
				.clk  (clk),
				.en   (en),
				.din  (chain[s]),
				.dout (chain[s+1])
			);
		end
		assign lane_out[k] = chain[DIV_STAGES];
	end

	ctl_t ctl_q [DIV_STAGES+1];
	always_ff @(posedge clk) begin
		if (en) begin
			ctl_q[0] <= ctl_s4;
			for (int s = 1; s <= DIV_STAGES; s++) begin
				ctl_q[s] <= ctl_q[s-1];
			end
		end
	end

	// Final stage: round, sign, saturate, and give zero when singular.
	logic [31:0] res [3];
	logic [QUO_W:0] qr;
	logic [DEN_W:0] r2;
	logic [DEN_W-1:0] rm;
	always_comb begin
		rm = '0;
		r2 = '0;
		qr = '0;
		for (int k = 0; k < 3; k++) begin
			rm = lane_out[k].rem[REM_W-1 -: DEN_W];
			r2 = {rm, 1'b0};
			qr = {1'b0, lane_out[k].quo}
				+ {{QUO_W{1'b0}}, (r2 >= {1'b0, ctl_q[DIV_STAGES].den})};
			if (ctl_q[DIV_STAGES].singular) begin
				res[k] = '0;
			end else if (lane_out[k].neg) begin
				res[k] = (lane_out[k].ovf || qr > 37'h80000000) ?
					32'h80000000 : 32'(-qr);
			end else begin
				res[k] = (lane_out[k].ovf || qr > 37'h7FFFFFFF) ?
					32'h7FFFFFFF : qr[31:0];
			end
		end
	end

	logic [95:0] out_q;
	logic singular_q;
	always_ff @(posedge clk) begin
		if (en) begin
			out_q <= {res[2], res[1], res[0]};
			singular_q <= ctl_q[DIV_STAGES].singular;
		end
	end
	assign m_tdata = out_q;
	assign m_tuser = singular_q;
endmodule
